@@ rtl/core/bfhp_pkg.sv @@
`timescale 1ns / 1ps

package bfhp_pkg;

  // result kinds
  localparam logic [2:0] KIND_DESIGN  = 3'd0;
  localparam logic [2:0] KIND_DEVICE  = 3'd1;
  localparam logic [2:0] KIND_DATE    = 3'd2;
  localparam logic [2:0] KIND_TIME    = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_PLEN    = 3'd5;
  localparam logic [2:0] KIND_BADKEY  = 3'd6;

  // field keys
  localparam logic [7:0] KEY_FIRST = 8'h61;  // 'a'
  localparam logic [2:0] KEY_IDX_PLEN = 3'd4; // 'e'

  localparam int unsigned PLEN_BYTES = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last;
  } res_t;

endpackage

@@ rtl/core/bfhp_if.sv @@
`timescale 1ns / 1ps

interface bfhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface bfhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic        last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

@@ rtl/core/bfhp_parse.sv @@
`timescale 1ns / 1ps

module bfhp_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_data_byte,
  input  logic           in_start_req,
  input  logic           res_ready,
  output logic           res_vld,
  output bfhp_pkg::res_t res
);

  typedef enum logic [3:0] {
    PH_HLEN_HI,
    PH_HLEN_LO,
    PH_HSKIP,
    PH_KEY,
    PH_SLEN_HI,
    PH_SLEN_LO,
    PH_STR,
    PH_PLEN,
    PH_PAYLOAD,
    PH_IDLE,
    PH_ERROR
  } phase_t;

  // input register
  logic           in_vld_r;
  logic [7:0]     byte_r;
  logic           start_r;

  logic           advance;

  phase_t         phase_r, phase_nxt, phase_eff;
  logic [31:0]    cnt_r, cnt_nxt, cnt_dec;
  logic [31:0]    acc_r, acc_nxt;
  logic [2:0]     key_r, key_nxt, key_eff;
  logic           emit_nxt;
  bfhp_pkg::res_t res_nxt;

  assign advance  = in_vld_r && res_ready;
  assign in_ready = !in_vld_r || advance;
  assign cnt_dec  = cnt_r - 32'd1;

  always_comb begin
    // a start word restarts the walk on this very byte
    phase_eff = start_r ? PH_HLEN_HI : phase_r;
    key_eff   = start_r ? 3'd0 : key_r;

    phase_nxt = phase_eff;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    key_nxt   = key_eff;
    emit_nxt  = 1'b0;
    res_nxt   = '{kind: bfhp_pkg::KIND_PAYLOAD, value: {24'd0, byte_r}, last: 1'b0};

    unique case (phase_eff)
      PH_HLEN_HI: begin
        acc_nxt   = {24'd0, byte_r};
        phase_nxt = PH_HLEN_LO;
      end
      PH_HLEN_LO: begin
        cnt_nxt   = {16'd0, acc_r[7:0], byte_r} + 32'd2;
        phase_nxt = PH_HSKIP;
      end
      PH_HSKIP: begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == 32'd0) begin
          phase_nxt = PH_KEY;
        end
      end
      PH_KEY: begin
        if (byte_r != bfhp_pkg::KEY_FIRST + {5'd0, key_eff}) begin
          phase_nxt     = PH_ERROR;
          emit_nxt      = 1'b1;
          res_nxt.kind  = bfhp_pkg::KIND_BADKEY;
        end else if (key_eff == bfhp_pkg::KEY_IDX_PLEN) begin
          cnt_nxt   = 32'd0;
          acc_nxt   = 32'd0;
          phase_nxt = PH_PLEN;
        end else begin
          phase_nxt = PH_SLEN_HI;
        end
      end
      PH_SLEN_HI: begin
        acc_nxt   = {24'd0, byte_r};
        phase_nxt = PH_SLEN_LO;
      end
      PH_SLEN_LO: begin
        cnt_nxt = {16'd0, acc_r[7:0], byte_r};
        if ({acc_r[7:0], byte_r} == 16'd0) begin
          key_nxt   = key_eff + 3'd1;
          phase_nxt = PH_KEY;
        end else begin
          phase_nxt = PH_STR;
        end
      end
      PH_STR: begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == 32'd0) begin
          key_nxt   = key_eff + 3'd1;
          phase_nxt = PH_KEY;
        end
        // the terminator byte gives no result
        if (cnt_r > 32'd1) begin
          emit_nxt     = 1'b1;
          res_nxt.kind = key_eff;
          res_nxt.last = (cnt_r == 32'd2);
        end
      end
      PH_PLEN: begin
        acc_nxt = {acc_r[23:0], byte_r};
        cnt_nxt = cnt_r + 32'd1;
        if (cnt_r == 32'(bfhp_pkg::PLEN_BYTES - 1)) begin
          cnt_nxt       = {acc_r[23:0], byte_r};
          phase_nxt     = ({acc_r[23:0], byte_r} == 32'd0) ? PH_IDLE : PH_PAYLOAD;
          emit_nxt      = 1'b1;
          res_nxt.kind  = bfhp_pkg::KIND_PLEN;
          res_nxt.value = {acc_r[23:0], byte_r};
        end
      end
      PH_PAYLOAD: begin
        cnt_nxt  = cnt_dec;
        emit_nxt = 1'b1;
        if (cnt_dec == 32'd0) begin
          phase_nxt    = PH_IDLE;
          res_nxt.last = 1'b1;
        end
      end
      PH_IDLE, PH_ERROR: begin
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      phase_r  <= PH_HLEN_HI;
      cnt_r    <= 32'd0;
      acc_r    <= 32'd0;
      key_r    <= 3'd0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
        byte_r   <= in_data_byte;
        start_r  <= in_start_req;
      end
      if (advance) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        acc_r   <= acc_nxt;
        key_r   <= key_nxt;
      end
    end
  end

  assign res_vld = advance && emit_nxt;
  assign res     = res_nxt;

endmodule

@@ rtl/core/bfhp_out_skid.sv @@
`timescale 1ns / 1ps

module bfhp_out_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bfhp_pkg::res_t push_data,
  output logic           push_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output bfhp_pkg::res_t out_data
);

  logic           main_vld_r;
  logic           skid_vld_r;
  bfhp_pkg::res_t main_r;
  bfhp_pkg::res_t skid_r;

  assign push_ready = !skid_vld_r;
  assign out_valid  = main_vld_r;
  assign out_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!main_vld_r || out_ready) begin
      if (skid_vld_r) begin
        main_r     <= skid_r;
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        main_r     <= push_data;
        main_vld_r <= push;
      end
    end else if (push) begin
      // main word stalled, park the new one
      skid_r     <= push_data;
      skid_vld_r <= 1'b1;
    end
  end

endmodule

@@ rtl/core/bit_file_header_parser_core.sv @@
`timescale 1ns / 1ps
// path: a byte accepted into the input register is parsed, and its word, if any,
// is registered in the two-entry output register; throughput: one byte per cycle
// while the output skid entry is empty, set by the combinational parse step
// reset: synchronous active-low rst_n returns the parser to the first header
// length byte and empties both register stages

module bit_file_header_parser_core (
  input logic        clk,
  input logic        rst_n,
  bfhp_in_if.sink    in_ch,
  bfhp_out_if.source out_ch
);

  logic           res_vld;
  logic           res_ready;
  bfhp_pkg::res_t res;
  bfhp_pkg::res_t out_data;

  bfhp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data_byte (in_ch.data_byte),
    .in_start_req (in_ch.start_req),
    .res_ready    (res_ready),
    .res_vld      (res_vld),
    .res          (res)
  );

  bfhp_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_vld),
    .push_data  (res),
    .push_ready (res_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_data)
  );

  assign out_ch.kind  = out_data.kind;
  assign out_ch.value = out_data.value;
  assign out_ch.last  = out_data.last;

endmodule
